>>> src/rau_pkg.sv
// shared constants for the rational arithmetic unit
package rau_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int PRODUCT_WIDTH = 2 * OPERAND_WIDTH;
  localparam int WORD_WIDTH    = 64;
  localparam int SHIFT_WIDTH   = 6;
  localparam int COUNT_WIDTH   = 6;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  localparam logic [WORD_WIDTH-1:0] SIGN64 = {1'b1, {(WORD_WIDTH-1){1'b0}}};

endpackage

>>> src/rational_arithmetic_unit.sv
// rational arithmetic unit: fraction add/sub/mul/div with gcd reduction
//
// Takes one item of two signed fractions and an operation, and returns one
// reduced fraction with a positive denominator and a status code. The item
// is worked on by a small sequencer around shared units: one signed
// multiplier forms the three products one after another, a binary gcd
// loop (one shift or one 64-bit compare and subtract a cycle) finds the
// divisor, and one restoring divider, one quotient bit a cycle, divides
// the numerator and then the denominator. A zero denominator, an overflow
// or a zero numerator ends the item once the products are combined;
// in_ready is low while the item is at work. A finished result sits in an
// output register, so the next item is taken while the last result still
// waits for out_ready.
module rational_arithmetic_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          mode,
  input  logic signed [31:0]                  lhs_numerator,
  input  logic signed [31:0]                  lhs_denominator,
  input  logic signed [31:0]                  rhs_numerator,
  input  logic signed [31:0]                  rhs_denominator,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [63:0]                  result_numerator,
  output logic [62:0]                         result_denominator,
  output logic [1:0]                          status
);

  localparam int W  = rau_pkg::OPERAND_WIDTH;
  localparam int PW = rau_pkg::PRODUCT_WIDTH;
  localparam int WW = rau_pkg::WORD_WIDTH;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_MUL0  = 11'b000_0000_0010,
    S_MUL1  = 11'b000_0000_0100,
    S_MUL2  = 11'b000_0000_1000,
    S_COMB  = 11'b000_0001_0000,
    S_GSH   = 11'b000_0010_0000,
    S_GSA   = 11'b000_0100_0000,
    S_GLOOP = 11'b000_1000_0000,
    S_DIVN  = 11'b001_0000_0000,
    S_DIVD  = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  state_t state;

  // operand registers, loaded with the full operand width
  logic [1:0]          op_mode;
  logic signed [W-1:0] ln, ld, rn, rd;

  // shared multiplier
  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic [WW-1:0]        prod64;

  // cross products
  logic [WW-1:0] p1, p2, den;
  logic [WW-1:0] num_c;
  logic          ovf_c;

  // gcd datapath
  logic [WW-1:0]          ga, gb, nm, dm, g;
  logic [rau_pkg::SHIFT_WIDTH-1:0] sh;
  logic                   neg;
  logic                   ga_gt;
  logic [WW-1:0]          sub_x, sub_y, diff;

  // divider datapath
  logic [WW-1:0]  div_n, div_rem, qn;
  logic [WW:0]    div_t;
  logic           div_ge;
  logic [WW-1:0]  div_n_next, div_rem_next;
  logic [rau_pkg::COUNT_WIDTH-1:0] cnt;

  // final result before the output register
  logic [WW-1:0] fin_num;
  logic [62:0]   fin_den;
  logic [1:0]    fin_status;
  logic          qovf;
  logic [WW-1:0] qd;

  assign in_ready = (state == S_IDLE);

  // operand select for the one multiplier
  always_comb begin
    mul_a = ln;
    mul_b = rd;
    case (state)
      S_MUL0: begin
        mul_a = ln;
        mul_b = (op_mode == rau_pkg::MODE_MUL) ? rn : rd;
      end
      S_MUL1: begin
        mul_a = rn;
        mul_b = ld;
      end
      S_MUL2: begin
        mul_a = ld;
        mul_b = (op_mode == rau_pkg::MODE_DIV) ? rn : rd;
      end
      default: begin
        mul_a = ln;
        mul_b = rd;
      end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign prod64 = WW'(prod);

  // sum or difference of cross products with overflow check; mul and div pass p1 on
  always_comb begin
    num_c = p1;
    ovf_c = 1'b0;
    case (op_mode)
      rau_pkg::MODE_ADD: begin
        num_c = p1 + p2;
        ovf_c = (((p1 ^ p2) & rau_pkg::SIGN64) == '0) &&
                (((num_c ^ p1) & rau_pkg::SIGN64) != '0);
      end
      rau_pkg::MODE_SUB: begin
        num_c = p1 - p2;
        ovf_c = (((p1 ^ p2) & rau_pkg::SIGN64) != '0) &&
                (((num_c ^ p1) & rau_pkg::SIGN64) != '0);
      end
      default: begin
        num_c = p1;
        ovf_c = 1'b0;
      end
    endcase
  end

  // one compare and subtract per gcd step
  assign ga_gt = (ga > gb);
  assign sub_x = ga_gt ? ga : gb;
  assign sub_y = ga_gt ? gb : ga;
  assign diff  = sub_x - sub_y;

  // restoring divider step
  assign div_t        = {div_rem, div_n[WW-1]};
  assign div_ge       = (div_t >= {1'b0, g});
  assign div_rem_next = div_ge ? WW'(div_t - {1'b0, g}) : div_t[WW-1:0];
  assign div_n_next   = {div_n[WW-2:0], div_ge};

  // range check on the reduced fraction
  assign qd   = div_n_next;
  assign qovf = (!neg && qn[WW-1]) || (neg && (qn > rau_pkg::SIGN64)) || qd[WW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_mode <= mode;
            ln      <= lhs_numerator[W-1:0];
            ld      <= lhs_denominator[W-1:0];
            rn      <= rhs_numerator[W-1:0];
            rd      <= rhs_denominator[W-1:0];
            state   <= S_MUL0;
          end
        end
        S_MUL0: begin
          p1    <= prod64;
          state <= S_MUL1;
        end
        S_MUL1: begin
          p2    <= prod64;
          state <= S_MUL2;
        end
        S_MUL2: begin
          den   <= prod64;
          state <= S_COMB;
        end
        S_COMB: begin
          neg <= ((num_c ^ den) & rau_pkg::SIGN64) != '0;
          nm  <= num_c[WW-1] ? (WW'(0) - num_c) : num_c;
          dm  <= den[WW-1] ? (WW'(0) - den) : den;
          ga  <= num_c[WW-1] ? (WW'(0) - num_c) : num_c;
          gb  <= den[WW-1] ? (WW'(0) - den) : den;
          sh  <= '0;
          if (den == '0) begin
            fin_num    <= '0;
            fin_den    <= '0;
            fin_status <= rau_pkg::STATUS_ZERO_DEN;
            state      <= S_DONE;
          end else if (ovf_c) begin
            fin_num    <= '0;
            fin_den    <= '0;
            fin_status <= rau_pkg::STATUS_OVERFLOW;
            state      <= S_DONE;
          end else if (num_c == '0) begin
            fin_num    <= '0;
            fin_den    <= 63'd1;
            fin_status <= rau_pkg::STATUS_OK;
            state      <= S_DONE;
          end else begin
            state <= S_GSH;
          end
        end
        S_GSH: begin
          // strip common factors of two
          if (((ga | gb) & WW'(1)) == '0) begin
            ga <= ga >> 1;
            gb <= gb >> 1;
            sh <= sh + 1'b1;
          end else begin
            state <= S_GSA;
          end
        end
        S_GSA: begin
          if (!ga[0]) begin
            ga <= ga >> 1;
          end else begin
            state <= S_GLOOP;
          end
        end
        S_GLOOP: begin
          if (gb == '0) begin
            g       <= ga << sh;
            div_n   <= nm;
            div_rem <= '0;
            cnt     <= '0;
            state   <= S_DIVN;
          end else if (!gb[0]) begin
            gb <= gb >> 1;
          end else begin
            ga <= sub_y;
            gb <= diff;
          end
        end
        S_DIVN: begin
          cnt <= cnt + 1'b1;
          if (cnt == '1) begin
            qn      <= div_n_next;
            div_n   <= dm;
            div_rem <= '0;
            state   <= S_DIVD;
          end else begin
            div_n   <= div_n_next;
            div_rem <= div_rem_next;
          end
        end
        S_DIVD: begin
          cnt     <= cnt + 1'b1;
          div_n   <= div_n_next;
          div_rem <= div_rem_next;
          if (cnt == '1) begin
            if (qovf) begin
              fin_num    <= '0;
              fin_den    <= '0;
              fin_status <= rau_pkg::STATUS_OVERFLOW;
            end else begin
              fin_num    <= neg ? (WW'(0) - qn) : qn;
              fin_den    <= qd[62:0];
              fin_status <= rau_pkg::STATUS_OK;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hand over once the output register is free
          if (!out_valid || out_ready) begin
            result_numerator   <= fin_num;
            result_denominator <= fin_den;
            status             <= fin_status;
            out_valid          <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a good result always has a nonzero denominator
  a_ok_den: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == rau_pkg::STATUS_OK) |-> result_denominator != '0)
    else $error("ok result with zero denominator");

  // error results carry a zero fraction
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != rau_pkg::STATUS_OK) |->
      (result_numerator == '0) && (result_denominator == '0))
    else $error("error result with nonzero fraction");

  // an accepted item keeps the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accepting an item");

  // the divisor is never zero while dividing
  a_div_g: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVN) || (state == S_DIVD) |-> g != '0)
    else $error("division by zero divisor");

endmodule

>>> bench/rational_arithmetic_unit_test.sv
// self-checking bench for the rational arithmetic unit
`timescale 1ns / 100ps

module rational_arithmetic_unit_test;

  // one expected reduced fraction
  typedef struct {
    logic signed [63:0] num;
    logic [62:0]        den;
    logic [1:0]         stat;
  } fraction_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [1:0] mode;
  logic signed [31:0] lhs_numerator;
  logic signed [31:0] lhs_denominator;
  logic signed [31:0] rhs_numerator;
  logic signed [31:0] rhs_denominator;
  logic out_valid;
  logic out_ready;
  logic signed [63:0] result_numerator;
  logic [62:0] result_denominator;
  logic [1:0] status;

  int error_count;
  int send_idle_pct;
  int take_idle_pct;
  longint unsigned cycle_count;

  rational_arithmetic_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode),
    .lhs_numerator(lhs_numerator), .lhs_denominator(lhs_denominator),
    .rhs_numerator(rhs_numerator), .rhs_denominator(rhs_denominator),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_numerator(result_numerator), .result_denominator(result_denominator),
    .status(status)
  );

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // binary gcd, both arguments nonzero
  function automatic logic [63:0] common_divisor(input logic [63:0] a, input logic [63:0] b);
    int shift;
    logic [63:0] t;
    shift = 0;
    while (((a | b) & 64'd1) == 0) begin
      a = a >> 1;
      b = b >> 1;
      shift++;
    end
    while (a[0] == 1'b0) a = a >> 1;
    while (b != 0) begin
      while (b[0] == 1'b0) b = b >> 1;
      if (a > b) begin
        t = a;
        a = b;
        b = t;
      end
      b = b - a;
    end
    return a << shift;
  endfunction

  // expected fraction for one item
  function automatic fraction_t reduce_fraction(input logic [1:0] op,
      input logic signed [31:0] ln, input logic signed [31:0] ld,
      input logic signed [31:0] rn, input logic signed [31:0] rd);
    fraction_t r;
    logic [63:0] p1, p2, num, den, nm, dm, g;
    logic ovf, neg;
    ovf = 1'b0;
    p1 = 64'(longint'(ln) * longint'(rd));
    p2 = 64'(longint'(rn) * longint'(ld));
    den = 64'(longint'(ld) * longint'(rd));
    case (op)
      rau_pkg::MODE_ADD: begin
        num = p1 + p2;
        ovf = (p1[63] == p2[63]) && (num[63] != p1[63]);
      end
      rau_pkg::MODE_SUB: begin
        num = p1 - p2;
        ovf = (p1[63] != p2[63]) && (num[63] != p1[63]);
      end
      rau_pkg::MODE_MUL: num = 64'(longint'(ln) * longint'(rn));
      default: begin
        num = p1;
        den = 64'(longint'(ld) * longint'(rn));
      end
    endcase
    r.num = 0;
    r.den = 0;
    r.stat = rau_pkg::STATUS_OK;
    if (den == 0) r.stat = rau_pkg::STATUS_ZERO_DEN;
    else if (ovf) r.stat = rau_pkg::STATUS_OVERFLOW;
    else if (num == 0) r.den = 63'd1;
    else begin
      neg = num[63] ^ den[63];
      nm = num[63] ? -num : num;
      dm = den[63] ? -den : den;
      g = common_divisor(nm, dm);
      nm = nm / g;
      dm = dm / g;
      if ((!neg && nm > 64'h7fffffffffffffff) || (neg && nm > rau_pkg::SIGN64) ||
          dm > 64'h7fffffffffffffff)
        r.stat = rau_pkg::STATUS_OVERFLOW;
      else begin
        r.num = neg ? -nm : nm;
        r.den = dm[62:0];
      end
    end
    return r;
  endfunction

  // queue of expected fractions, oldest first
  class fraction_board;
    fraction_t pending[$];

    function void note_item(input logic [1:0] op, input logic signed [31:0] ln,
        input logic signed [31:0] ld, input logic signed [31:0] rn,
        input logic signed [31:0] rd);
      pending.push_back(reduce_fraction(op, ln, ld, rn, rd));
    endfunction

    task check_result(input logic signed [63:0] num, input logic [62:0] den,
                      input logic [1:0] stat);
      fraction_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", num, 0);
        return;
      end
      want = pending.pop_front();
      if (num !== want.num) report_mismatch("numerator", num, want.num);
      if (den !== want.den) report_mismatch("denominator", 64'(den), 64'(want.den));
      if (stat !== want.stat) report_mismatch("status", 64'(stat), 64'(want.stat));
    endtask
  endclass

  fraction_board board;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // cycle counter doubles as the run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 64'd3000000) begin
      $display("rational_arithmetic_unit_test: FAIL");
      $finish;
    end
  end

  // sample accepted results at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_result(result_numerator, result_denominator, status);
  end

  // receiver stalls at random, decided at the falling edge
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= take_idle_pct);
  end

  // present one item, hold it until taken; valid drops only on an idle cycle
  task automatic send_item(input logic [1:0] op, input logic [31:0] ln,
      input logic [31:0] ld, input logic [31:0] rn, input logic [31:0] rd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= op;
    lhs_numerator <= ln;
    lhs_denominator <= ld;
    rhs_numerator <= rn;
    rhs_denominator <= rd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_item(op, ln, ld, rn, rd);
    @(negedge clk);
  endtask

  // operand drawn from the interesting corners or at random
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'($signed($urandom_range(8)) - 4);
      3: return 32'($urandom_range(255)) << $urandom_range(24);
      4: return -(32'($urandom_range(1000)));
      5: return 32'($urandom_range(1000));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] corner[6];
    int phase, n;
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 20;
    take_idle_pct = 77;
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    mode = rau_pkg::MODE_ADD;
    lhs_numerator = 0;
    lhs_denominator = 1;
    rhs_numerator = 0;
    rhs_denominator = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: every operation, extremes, zero denominators and numerators,
    // sign normalization, common factors
    corner = '{32'h80000000, 32'h7fffffff, 32'h0, 32'h1, 32'hffffffff, 32'd6};
    send_item(rau_pkg::MODE_ADD, 32'h7fffffff, 32'd1, 32'h7fffffff, 32'd1);
    send_item(rau_pkg::MODE_ADD, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_item(rau_pkg::MODE_SUB, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_item(rau_pkg::MODE_MUL, 32'h80000000, 32'hffffffff, 32'h80000000, 32'hffffffff);
    send_item(rau_pkg::MODE_MUL, 32'h80000000, 32'd1, 32'h80000000, 32'd1);
    send_item(rau_pkg::MODE_DIV, 32'd3, 32'd4, 32'd0, 32'd5);
    send_item(rau_pkg::MODE_ADD, 32'd1, 32'd0, 32'd1, 32'd2);
    send_item(rau_pkg::MODE_SUB, 32'd5, 32'd7, 32'd5, 32'd7);
    send_item(rau_pkg::MODE_DIV, 32'd6, 32'hfffffff8, 32'd9, 32'd12);
    send_item(rau_pkg::MODE_MUL, 32'hfffffffe, 32'hfffffffd, 32'd0, 32'hffffffff);
    send_item(rau_pkg::MODE_ADD, 32'd1, 32'd2, 32'd1, 32'd2);
    send_item(rau_pkg::MODE_SUB, 32'h7fffffff, 32'h80000000, 32'd1, 32'h7fffffff);
    for (int i = 0; i < 12; i++)
      send_item(2'(i), corner[i % 6], corner[(i + 1) % 6], corner[(i + 3) % 6],
                corner[(i + 5) % 6]);

    // random items over three idling phases
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 77 : 0;
      take_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 20 : 0;
      n = 0;
      while (n < 650) begin
        send_item(2'($urandom_range(3)), pick_operand(), pick_operand(),
                  pick_operand(), pick_operand());
        n++;
      end
    end
    in_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (error_count == 0)
      $display("rational_arithmetic_unit_test: PASS");
    else
      $display("rational_arithmetic_unit_test: FAIL");
    $finish;
  end

endmodule
